// ===== src/flywheel_spindown_inertia_calibrator_macros.svh =====
// Assertion helpers shared by the calibrator modules.
`ifndef FLYWHEEL_SPINDOWN_INERTIA_CALIBRATOR_MACROS_SVH
`define FLYWHEEL_SPINDOWN_INERTIA_CALIBRATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FSIC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FSIC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fsic_pkg.sv =====
// ---------------------------------------------------------------------------
// fsic_pkg
// Types and constants of the flywheel spindown inertia calibrator.
// ---------------------------------------------------------------------------
package fsic_pkg;

  localparam int VEL_W   = 24;
  localparam int TIME_W  = 48;
  localparam int DRAG_W  = 26;
  localparam int INER_W  = 25;
  localparam int CODE_W  = 4;
  localparam int CNT_W   = 4;
  localparam int CFG_W   = 48;
  localparam int PROD_W  = 2 * VEL_W;              // w0*wf
  localparam int NUM_W   = PROD_W + TIME_W + DRAG_W; // k*dt*w0*wf
  localparam int DEN_W   = 44;                     // 1e6*(w0-wf)
  localparam int QUO_W   = 45;                     // quotient bits below overflow
  localparam int STEP_W  = 6;

  localparam int SPINUP_DEBOUNCE   = 3;
  localparam int SPINDOWN_DEBOUNCE = 3;

  localparam logic [VEL_W-1:0]  VEL_MIN   = 24'd81920;    // 20 rad/s
  localparam logic [VEL_W-1:0]  DROP_MIN  = 24'd20480;    // 5 rad/s
  localparam logic [TIME_W-1:0] DT_MIN    = 48'd1000000;
  localparam logic [INER_W-1:0] INER_MIN  = 25'd167773;   // 0.01
  localparam logic [INER_W-1:0] INER_MAX  = 25'd16777216; // 1.0
  localparam logic [DRAG_W-1:0] DENOM_K   = 26'd40960000;
  localparam logic [19:0]       US_PER_S  = 20'd1000000;

  localparam logic [DRAG_W-1:0] RST_DRAG     = 26'd429497;
  localparam logic [CFG_W-1:0]  RST_OVERALL  = 48'd60000000;
  localparam logic [CFG_W-1:0]  RST_STOP     = 48'd2000000;

  typedef enum logic [1:0] {
    OP_PULSE  = 2'd0,
    OP_TICK   = 2'd1,
    OP_START  = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_DRAG    = 2'd0,
    CFG_OVERALL = 2'd1,
    CFG_STOP    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAITING  = 3'd1,
    PH_SPINUP   = 3'd2,
    PH_SPINDOWN = 3'd3,
    PH_COMPLETE = 3'd4,
    PH_FAILED   = 3'd5
  } phase_t;

  localparam logic [CODE_W-1:0] FC_NONE     = 4'd0;
  localparam logic [CODE_W-1:0] FC_TIMEOUT  = 4'd1;
  localparam logic [CODE_W-1:0] FC_DRAG     = 4'd2;
  localparam logic [CODE_W-1:0] FC_VELOCITY = 4'd3;
  localparam logic [CODE_W-1:0] FC_DROP     = 4'd4;
  localparam logic [CODE_W-1:0] FC_DT       = 4'd5;
  localparam logic [CODE_W-1:0] FC_SHORT    = 4'd6;
  localparam logic [CODE_W-1:0] FC_DENOM    = 4'd7;
  localparam logic [CODE_W-1:0] FC_OVERFLOW = 4'd8;
  localparam logic [CODE_W-1:0] FC_RANGE    = 4'd9;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_EVAL,
    DP_PREP,
    DP_CHKFAIL,
    DP_MULK_INIT,
    DP_MSTEP,
    DP_MULT_INIT,
    DP_OVF_FAIL,
    DP_DIV_INIT,
    DP_DSTEP,
    DP_FINISH,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_fin;
    logic pre_fail;
    logic ovf;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_CHECK,
    ST_MULK,
    ST_MTINIT,
    ST_MULT,
    ST_DIVCHK,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } ctrl_state_t;

endpackage

// ===== src/fsic_dp.sv =====
// ---------------------------------------------------------------------------
// fsic_dp
// Calibration state, event update, serial multiplier and restoring divider.
// ---------------------------------------------------------------------------
`include "flywheel_spindown_inertia_calibrator_macros.svh"

module fsic_dp #(
  parameter int SPINUP_DEBOUNCE   = fsic_pkg::SPINUP_DEBOUNCE,
  parameter int SPINDOWN_DEBOUNCE = fsic_pkg::SPINDOWN_DEBOUNCE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [fsic_pkg::CFG_W-1:0]  cfg_data,
  input  logic [1:0]                  in_op,
  input  logic [fsic_pkg::VEL_W-1:0]  in_vel,
  input  logic [fsic_pkg::TIME_W-1:0] in_time,
  input  fsic_pkg::dp_cmd_t           cmd,
  output fsic_pkg::dp_stat_t          stat,
  output logic [63:0]                 out_word
);

  localparam int VW = fsic_pkg::VEL_W;
  localparam int TW = fsic_pkg::TIME_W;
  localparam int NW = fsic_pkg::NUM_W;
  localparam int DW = fsic_pkg::DEN_W;
  localparam int QW = fsic_pkg::QUO_W;

  // configuration
  logic [fsic_pkg::DRAG_W-1:0] drag_cfg;
  logic [TW-1:0]               overall_to;
  logic [TW-1:0]               stop_to;

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_cfg   <= fsic_pkg::RST_DRAG;
      overall_to <= fsic_pkg::RST_OVERALL;
      stop_to    <= fsic_pkg::RST_STOP;
    end else if (cfg_we) begin
      unique case (fsic_pkg::cfg_idx_t'(cfg_addr))
        fsic_pkg::CFG_DRAG:    drag_cfg   <= cfg_data[fsic_pkg::DRAG_W-1:0];
        fsic_pkg::CFG_OVERALL: overall_to <= cfg_data;
        fsic_pkg::CFG_STOP:    stop_to    <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched word
  fsic_pkg::op_t op_r;
  logic [VW-1:0] vel_r;
  logic [TW-1:0] time_r;

  // calibration state
  fsic_pkg::phase_t            phase;
  fsic_pkg::phase_t            prev_phase;
  logic [TW-1:0]               start_time;
  logic [TW-1:0]               last_pulse;
  logic [fsic_pkg::DRAG_W-1:0] drag_use;
  logic [VW-1:0]               peak_vel;
  logic [TW-1:0]               peak_time;
  logic [VW-1:0]               final_vel;
  logic [TW-1:0]               final_time;
  logic [fsic_pkg::CNT_W-1:0]  up_cnt;
  logic [fsic_pkg::CNT_W-1:0]  down_cnt;
  logic [fsic_pkg::INER_W-1:0] inertia;
  logic [fsic_pkg::CODE_W-1:0] fcode;

  // arithmetic
  logic [fsic_pkg::PROD_W-1:0] prod;
  logic [49:0]                 dcheck;
  logic [DW-1:0]               den;
  logic [TW-1:0]               dt;
  logic [fsic_pkg::CODE_W-1:0] pre_code;
  logic [NW-1:0]               mcand;
  logic [NW-1:0]               acc;
  logic [TW-1:0]               mplier;
  logic [DW-1:0]               rem;
  logic [QW-1:0]               qn;

  logic [63:0] out_r;

  logic                        active;
  logic                        timed_out;
  logic                        stop_seen;
  logic [VW-1:0]               diff;
  logic [TW-1:0]               dt_c;
  logic [fsic_pkg::CODE_W-1:0] pre_code_c;
  logic [fsic_pkg::CNT_W-1:0]  up_inc;
  logic [fsic_pkg::CNT_W-1:0]  down_inc;
  logic                        below85;
  logic [DW:0]                 div_r2;
  logic                        div_ge;
  logic [fsic_pkg::INER_W-1:0] iq;

  always_comb begin
    active = (phase == fsic_pkg::PH_WAITING) || (phase == fsic_pkg::PH_SPINUP) ||
             (phase == fsic_pkg::PH_SPINDOWN);
    timed_out = {1'b0, time_r} > ({1'b0, start_time} + {1'b0, overall_to});
    stop_seen = (last_pulse != '0) && ({1'b0, time_r} >= ({1'b0, last_pulse} + {1'b0, stop_to}));
    up_inc    = (up_cnt == '1) ? up_cnt : up_cnt + 1'b1;
    down_inc  = (down_cnt == '1) ? down_cnt : down_cnt + 1'b1;
    below85   = (29'(vel_r) * 29'd20) < (29'(peak_vel) * 29'd17);
    diff      = peak_vel - final_vel;
    dt_c      = final_time - peak_time;
    if (drag_use == '0)
      pre_code_c = fsic_pkg::FC_DRAG;
    else if (peak_vel == '0 || final_vel == '0)
      pre_code_c = fsic_pkg::FC_VELOCITY;
    else if (peak_vel < final_vel || diff < fsic_pkg::DROP_MIN)
      pre_code_c = fsic_pkg::FC_DROP;
    else if (final_time <= peak_time)
      pre_code_c = fsic_pkg::FC_DT;
    else if (dt_c < fsic_pkg::DT_MIN)
      pre_code_c = fsic_pkg::FC_SHORT;
    else
      pre_code_c = fsic_pkg::FC_NONE;
    div_r2 = {rem, qn[QW-1]};
    div_ge = div_r2 >= {1'b0, den};
    iq     = qn[QW-1:QW-fsic_pkg::INER_W];
  end

  assign stat.need_fin = (op_r == fsic_pkg::OP_TICK) && active && !timed_out &&
                         (phase == fsic_pkg::PH_SPINDOWN) && stop_seen;
  assign stat.pre_fail = (pre_code != fsic_pkg::FC_NONE) || (dcheck < 50'(prod));
  assign stat.ovf      = acc[NW-1:QW] >= (NW-QW)'(den);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= fsic_pkg::PH_IDLE;
      prev_phase <= fsic_pkg::PH_IDLE;
      start_time <= '0;
      last_pulse <= '0;
      drag_use   <= '0;
      peak_vel   <= '0;
      peak_time  <= '0;
      final_vel  <= '0;
      final_time <= '0;
      up_cnt     <= '0;
      down_cnt   <= '0;
      inertia    <= '0;
      fcode      <= '0;
    end else begin
      unique case (cmd.op)
        fsic_pkg::DP_EVAL: begin
          prev_phase <= phase;
          unique case (op_r)
            fsic_pkg::OP_START: begin
              phase      <= fsic_pkg::PH_WAITING;
              start_time <= time_r;
              last_pulse <= '0;
              drag_use   <= drag_cfg;
              peak_vel   <= '0;
              peak_time  <= '0;
              final_vel  <= '0;
              final_time <= '0;
              up_cnt     <= '0;
              down_cnt   <= '0;
              inertia    <= '0;
              fcode      <= '0;
            end
            fsic_pkg::OP_CANCEL: phase <= fsic_pkg::PH_IDLE;
            fsic_pkg::OP_TICK: begin
              if (active && timed_out) begin
                phase <= fsic_pkg::PH_FAILED;
                fcode <= fsic_pkg::FC_TIMEOUT;
              end
            end
            fsic_pkg::OP_PULSE: begin
              if (active) begin
                last_pulse <= time_r;
                if (timed_out) begin
                  phase <= fsic_pkg::PH_FAILED;
                  fcode <= fsic_pkg::FC_TIMEOUT;
                end else if (phase == fsic_pkg::PH_WAITING) begin
                  if (vel_r > fsic_pkg::VEL_MIN) begin
                    up_cnt <= up_inc;
                    if (up_inc >= fsic_pkg::CNT_W'(SPINUP_DEBOUNCE)) begin
                      phase     <= fsic_pkg::PH_SPINUP;
                      peak_vel  <= vel_r;
                      peak_time <= time_r;
                    end
                  end else begin
                    up_cnt <= '0;
                  end
                end else if (phase == fsic_pkg::PH_SPINUP) begin
                  if (vel_r > peak_vel) begin
                    peak_vel  <= vel_r;
                    peak_time <= time_r;
                    down_cnt  <= '0;
                  end else if (below85) begin
                    down_cnt <= down_inc;
                    if (down_inc >= fsic_pkg::CNT_W'(SPINDOWN_DEBOUNCE)) begin
                      phase      <= fsic_pkg::PH_SPINDOWN;
                      final_vel  <= vel_r;
                      final_time <= time_r;
                    end
                  end else begin
                    down_cnt <= '0;
                  end
                end else begin
                  final_vel  <= vel_r;
                  final_time <= time_r;
                end
              end
            end
            default: ;
          endcase
        end
        fsic_pkg::DP_PREP: inertia <= '0;
        fsic_pkg::DP_CHKFAIL: begin
          phase <= fsic_pkg::PH_FAILED;
          fcode <= (pre_code != fsic_pkg::FC_NONE) ? pre_code : fsic_pkg::FC_DENOM;
        end
        fsic_pkg::DP_OVF_FAIL: begin
          phase <= fsic_pkg::PH_FAILED;
          fcode <= fsic_pkg::FC_OVERFLOW;
        end
        fsic_pkg::DP_FINISH: begin
          inertia <= iq;
          if (iq < fsic_pkg::INER_MIN || iq > fsic_pkg::INER_MAX) begin
            phase <= fsic_pkg::PH_FAILED;
            fcode <= fsic_pkg::FC_RANGE;
          end else begin
            phase <= fsic_pkg::PH_COMPLETE;
            fcode <= fsic_pkg::FC_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      fsic_pkg::DP_LOAD: begin
        op_r   <= fsic_pkg::op_t'(in_op);
        vel_r  <= in_vel;
        time_r <= in_time;
      end
      fsic_pkg::DP_PREP: begin
        prod     <= fsic_pkg::PROD_W'(peak_vel) * fsic_pkg::PROD_W'(final_vel);
        dcheck   <= 50'(diff) * 50'(fsic_pkg::DENOM_K);
        den      <= DW'(diff) * DW'(fsic_pkg::US_PER_S);
        dt       <= dt_c;
        pre_code <= pre_code_c;
      end
      fsic_pkg::DP_MULK_INIT: begin
        mcand  <= NW'(prod);
        mplier <= TW'(drag_use);
        acc    <= '0;
      end
      fsic_pkg::DP_MULT_INIT: begin
        mcand  <= acc;
        mplier <= dt;
        acc    <= '0;
      end
      fsic_pkg::DP_MSTEP: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[NW-2:0], 1'b0};
        mplier <= {1'b0, mplier[TW-1:1]};
      end
      fsic_pkg::DP_DIV_INIT: begin
        rem <= acc[QW+DW-1:QW];
        qn  <= acc[QW-1:0];
      end
      fsic_pkg::DP_DSTEP: begin
        rem <= div_ge ? DW'(div_r2 - {1'b0, den}) : div_r2[DW-1:0];
        qn  <= {qn[QW-2:0], div_ge};
      end
      fsic_pkg::DP_OUT: begin
        out_r <= {7'd0, peak_vel,
                  (phase == fsic_pkg::PH_FAILED) ? fcode : fsic_pkg::FC_NONE,
                  inertia, phase != prev_phase, phase};
      end
      default: ;
    endcase
  end

  assign out_word = out_r;

  `FSIC_ASSERT_IMP(a_fail_has_code, clk, rst, phase == fsic_pkg::PH_FAILED, fcode != fsic_pkg::FC_NONE, "failed phase without reason code")
  `FSIC_ASSERT_NXT(a_finish_ends, clk, rst, cmd.op == fsic_pkg::DP_FINISH, phase == fsic_pkg::PH_COMPLETE || phase == fsic_pkg::PH_FAILED, "finish did not end the run")

endmodule

// ===== src/fsic_ctrl.sv =====
// ---------------------------------------------------------------------------
// fsic_ctrl
// Sequencer: handshakes, event update and the finalize arithmetic steps.
// ---------------------------------------------------------------------------
`include "flywheel_spindown_inertia_calibrator_macros.svh"

module fsic_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  fsic_pkg::dp_stat_t stat,
  output fsic_pkg::dp_cmd_t  cmd
);

  localparam int SW = fsic_pkg::STEP_W;

  fsic_pkg::ctrl_state_t state, state_next;
  logic [SW-1:0] cnt, cnt_next;
  logic          out_free;
  logic          load_out;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fsic_pkg::ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = fsic_pkg::DP_NOP;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      fsic_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = fsic_pkg::DP_LOAD;
          state_next = fsic_pkg::ST_EVAL;
        end
      end
      fsic_pkg::ST_EVAL: begin
        cmd.op     = fsic_pkg::DP_EVAL;
        state_next = stat.need_fin ? fsic_pkg::ST_PREP : fsic_pkg::ST_DONE;
      end
      fsic_pkg::ST_PREP: begin
        cmd.op     = fsic_pkg::DP_PREP;
        state_next = fsic_pkg::ST_CHECK;
      end
      fsic_pkg::ST_CHECK: begin
        cnt_next = '0;
        if (stat.pre_fail) begin
          cmd.op     = fsic_pkg::DP_CHKFAIL;
          state_next = fsic_pkg::ST_DONE;
        end else begin
          cmd.op     = fsic_pkg::DP_MULK_INIT;
          state_next = fsic_pkg::ST_MULK;
        end
      end
      fsic_pkg::ST_MULK: begin
        cmd.op   = fsic_pkg::DP_MSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == SW'(fsic_pkg::DRAG_W - 1)) state_next = fsic_pkg::ST_MTINIT;
      end
      fsic_pkg::ST_MTINIT: begin
        cmd.op     = fsic_pkg::DP_MULT_INIT;
        cnt_next   = '0;
        state_next = fsic_pkg::ST_MULT;
      end
      fsic_pkg::ST_MULT: begin
        cmd.op   = fsic_pkg::DP_MSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == SW'(fsic_pkg::TIME_W - 1)) state_next = fsic_pkg::ST_DIVCHK;
      end
      fsic_pkg::ST_DIVCHK: begin
        cnt_next = '0;
        if (stat.ovf) begin
          cmd.op     = fsic_pkg::DP_OVF_FAIL;
          state_next = fsic_pkg::ST_DONE;
        end else begin
          cmd.op     = fsic_pkg::DP_DIV_INIT;
          state_next = fsic_pkg::ST_DIV;
        end
      end
      fsic_pkg::ST_DIV: begin
        cmd.op   = fsic_pkg::DP_DSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == SW'(fsic_pkg::QUO_W - 1)) state_next = fsic_pkg::ST_FIN;
      end
      fsic_pkg::ST_FIN: begin
        cmd.op     = fsic_pkg::DP_FINISH;
        state_next = fsic_pkg::ST_DONE;
      end
      fsic_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op     = fsic_pkg::DP_OUT;
          load_out   = 1'b1;
          state_next = fsic_pkg::ST_IDLE;
        end
      end
      default: state_next = fsic_pkg::ST_IDLE;
    endcase
  end

  `FSIC_ASSERT_NXT(a_accept_eval, clk, rst, s_tvalid && s_tready, state == fsic_pkg::ST_EVAL, "accepted word not evaluated")
  `FSIC_ASSERT_NXT(a_div_len, clk, rst, state == fsic_pkg::ST_DIV && cnt == SW'(fsic_pkg::QUO_W - 1), state == fsic_pkg::ST_FIN, "divider step count wrong")
  `FSIC_ASSERT_NXT(a_done_out, clk, rst, state == fsic_pkg::ST_DONE && out_free, m_tvalid, "result not presented")

endmodule

// ===== src/flywheel_spindown_inertia_calibrator.sv =====
// ---------------------------------------------------------------------------
// flywheel_spindown_inertia_calibrator
// Spindown calibration of flywheel inertia from pulse and tick events.
// ---------------------------------------------------------------------------
// Sequence: a word is loaded, evaluated and written to the output register; a tick
// that finalizes a run adds 26 + 48 multiply steps, 45 divide steps and overhead.
// Throughput: one word in flight; the shift-add multiplier and restoring
// divider set the finalize time. The output register frees the input side.
// Reset: synchronous, active high; state idle, config and run registers reset.
module flywheel_spindown_inertia_calibrator #(
  parameter int SPINUP_DEBOUNCE   = fsic_pkg::SPINUP_DEBOUNCE,
  parameter int SPINDOWN_DEBOUNCE = fsic_pkg::SPINDOWN_DEBOUNCE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [47:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // spin_rate[23:0], time_us[71:24]
  input  logic [1:0]  s_tuser,  // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // cal_state[2:0], changed[3], inertia[28:4],
                                // fail_reason[32:29], peak_velocity[56:33]
);

  fsic_pkg::dp_cmd_t  cmd;
  fsic_pkg::dp_stat_t stat;

  fsic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsic_dp #(
    .SPINUP_DEBOUNCE   (SPINUP_DEBOUNCE),
    .SPINDOWN_DEBOUNCE (SPINDOWN_DEBOUNCE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_op    (s_tuser),
    .in_vel   (s_tdata[23:0]),
    .in_time  (s_tdata[71:24]),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (m_tdata)
  );

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the flywheel spindown inertia calibrator. An in-bench model
// of the calibration state machine predicts one result word per event word.
// Directed events cover idle behavior, timestamp extremes, timeout and a
// clean completion. Randomized spin-up/spin-down sessions then run under
// several register settings and handshake idle patterns, including a long
// output back-pressure stretch.
// ---------------------------------------------------------------------------
module tb_top;
  import fsic_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 160;

  typedef struct packed {
    phase_t            st;
    logic              chg;
    logic [INER_W-1:0] iner;
    logic [CODE_W-1:0] reason;
    logic [VEL_W-1:0]  peak;
  } cal_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [47:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // spin_rate[23:0], time_us[71:24]
  logic [1:0]  s_tuser;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;   // cal_state[2:0], changed[3], inertia[28:4],
                          // fail_reason[32:29], peak_velocity[56:33]

  flywheel_spindown_inertia_calibrator uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of registers and run state
  logic [DRAG_W-1:0] drag_reg;
  logic [TIME_W-1:0] overall_reg, stop_reg;
  phase_t            ph;
  logic [TIME_W-1:0] t_start, t_lastp, t_peak, t_final;
  logic [DRAG_W-1:0] k_run;
  logic [VEL_W-1:0]  w_peak, w_final;
  logic [3:0]        n_up, n_down;
  logic [INER_W-1:0] iner_val;
  logic [CODE_W-1:0] fcode;

  cal_result_t pending_results[$];
  cal_result_t got;
  int  errors = 0, words_sent = 0, words_checked = 0, n_complete = 0, n_failed = 0;
  int  idle_pct = 0, stall_pct = 0, idle_cycles = 0, hold_left = 0;
  int  hold_req = 0, hold_ack = 0;
  longint now_us = 0;

  function automatic logic [CODE_W-1:0] inertia_code();
    logic [VEL_W-1:0]  diff;
    logic [TIME_W-1:0] dt;
    logic [47:0]       prod;
    logic [127:0]      num, quo;
    logic [63:0]       den;
    iner_val = '0;
    if (k_run == 0) return FC_DRAG;
    if (w_peak == 0 || w_final == 0) return FC_VELOCITY;
    if (w_peak < w_final || w_peak - w_final < DROP_MIN) return FC_DROP;
    if (t_final <= t_peak) return FC_DT;
    dt = t_final - t_peak;
    if (dt < DT_MIN) return FC_SHORT;
    diff = w_peak - w_final;
    prod = 48'(w_peak) * 48'(w_final);
    if (64'(diff) * 64'(DENOM_K) < 64'(prod)) return FC_DENOM;
    num = 128'(k_run) * 128'(dt) * 128'(prod);
    den = 64'(diff) * 64'd1000000;
    quo = num / 128'(den);
    if ((quo >> 45) != 0) return FC_OVERFLOW;
    iner_val = quo[44:20];
    if (iner_val < INER_MIN || iner_val > INER_MAX) return FC_RANGE;
    return FC_NONE;
  endfunction

  function automatic cal_result_t calib_step(op_t op, logic [VEL_W-1:0] v,
                                             logic [TIME_W-1:0] t);
    phase_t            prev;
    logic              active, late;
    logic [CODE_W-1:0] code;
    cal_result_t       r;
    prev   = ph;
    active = (ph == PH_WAITING || ph == PH_SPINUP || ph == PH_SPINDOWN);
    late   = {1'b0, t} > {1'b0, t_start} + {1'b0, overall_reg};
    case (op)
      OP_START: begin
        ph = PH_WAITING; t_start = t; t_lastp = '0; k_run = drag_reg;
        w_peak = '0; t_peak = '0; w_final = '0; t_final = '0;
        n_up = '0; n_down = '0; iner_val = '0; fcode = FC_NONE;
      end
      OP_CANCEL: ph = PH_IDLE;
      OP_PULSE: if (active) begin
        t_lastp = t;
        if (late) begin
          ph = PH_FAILED; fcode = FC_TIMEOUT;
        end else if (ph == PH_WAITING) begin
          if (v > VEL_MIN) begin
            if (n_up < 15) n_up++;
            if (n_up >= SPINUP_DEBOUNCE) begin
              ph = PH_SPINUP; w_peak = v; t_peak = t;
            end
          end else n_up = '0;
        end else if (ph == PH_SPINUP) begin
          if (v > w_peak) begin
            w_peak = v; t_peak = t; n_down = '0;
          end else if (32'(v) * 20 < 32'(w_peak) * 17) begin
            if (n_down < 15) n_down++;
            if (n_down >= SPINDOWN_DEBOUNCE) begin
              ph = PH_SPINDOWN; w_final = v; t_final = t;
            end
          end else n_down = '0;
        end else begin
          w_final = v; t_final = t;
        end
      end
      default: if (active) begin
        if (late) begin
          ph = PH_FAILED; fcode = FC_TIMEOUT;
        end else if (ph == PH_SPINDOWN && t_lastp != 0 &&
                     {1'b0, t} >= {1'b0, t_lastp} + {1'b0, stop_reg}) begin
          code = inertia_code();
          if (code == FC_NONE) begin
            ph = PH_COMPLETE; fcode = FC_NONE; n_complete++;
          end else begin
            ph = PH_FAILED; fcode = code;
          end
        end
      end
    endcase
    if (ph == PH_FAILED && prev != PH_FAILED) n_failed++;
    r.st     = ph;
    r.chg    = (ph != prev);
    r.iner   = iner_val;
    r.reason = (ph == PH_FAILED) ? fcode : FC_NONE;
    r.peak   = w_peak;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %0h, expected none", $time, m_tdata);
        errors++;
      end else begin
        got = pending_results.pop_front();
        check_field("cal_state", 64'(got.st), 64'(m_tdata[2:0]));
        check_field("changed", 64'(got.chg), 64'(m_tdata[3]));
        check_field("inertia", 64'(got.iner), 64'(m_tdata[28:4]));
        check_field("fail_reason", 64'(got.reason), 64'(m_tdata[32:29]));
        check_field("peak_velocity", 64'(got.peak), 64'(m_tdata[56:33]));
        words_checked++;
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_event(op_t op, logic [VEL_W-1:0] v, logic [TIME_W-1:0] t);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {t, v};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(calib_step(op, v, t));
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [DRAG_W-1:0] k, logic [47:0] ovr, logic [47:0] stp);
    cfg_we <= 1'b1; cfg_addr <= CFG_DRAG; cfg_data <= 48'(k);
    @(posedge clk); drag_reg = k;
    cfg_addr <= CFG_OVERALL; cfg_data <= ovr;
    @(posedge clk); overall_reg = ovr;
    cfg_addr <= CFG_STOP; cfg_data <= stp;
    @(posedge clk); stop_reg = stp;
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    longint t;
    send_event(OP_TICK, '0, '0);
    send_event(OP_PULSE, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF);
    send_event(OP_CANCEL, '0, 48'd5);
    // clean run: peak 100 rad/s, three readings at 50 rad/s, 1 s apart
    t = 1000;
    send_event(OP_START, 24'h123456, 48'(t));
    repeat (3) begin
      t += 100000; send_event(OP_PULSE, 24'd409600, 48'(t));
    end
    repeat (3) begin
      t += 1000000; send_event(OP_PULSE, 24'd204800, 48'(t));
    end
    send_event(OP_TICK, '0, 48'(t + 1000000));
    send_event(OP_TICK, '0, 48'(t + 2000000));
    send_event(OP_PULSE, 24'd409600, 48'(t + 2100000));
    // start near the top of the time range; the deadline sum must not wrap
    send_event(OP_START, '0, 48'hFFFF_FFFF_FFFF);
    send_event(OP_PULSE, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF);
    send_event(OP_TICK, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF);
    send_event(OP_CANCEL, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF);
    // run timeout
    send_event(OP_START, '0, '0);
    send_event(OP_PULSE, 24'd100000, 48'd60000000);
    send_event(OP_TICK, '0, 48'd60000001);
    send_event(OP_TICK, '0, 48'd60000002);
    now_us = 61000000;
  endtask

  task automatic spin_session();
    longint w_top, w, w_end, w_hi, t_back, dstop;
    int n, i, twist;
    now_us += $urandom_range(0, 1000000);
    send_event(OP_START, VEL_W'($urandom), 48'(now_us));
    n = $urandom_range(0, 3);
    repeat (n) begin
      now_us += $urandom_range(20000, 300000);
      send_event(OP_PULSE, VEL_W'($urandom_range(0, 81920)), 48'(now_us));
    end
    case ($urandom_range(0, 9))
      7, 8:    w_top = $urandom_range(1000 * 4096, 24'hFFFFFF);
      9:       w_top = $urandom_range(81921, 24'hFFFFFF);
      default: w_top = $urandom_range(30 * 4096, 300 * 4096);
    endcase
    n = $urandom_range(3, 8);
    for (i = 1; i <= n; i++) begin
      w = 81921 + (w_top - 81921) * i / n;
      if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 24'hFFFFFF);
      now_us += $urandom_range(20000, 400000);
      send_event(OP_PULSE, VEL_W'(w), 48'(now_us));
    end
    n = $urandom_range(3, 12);
    w_end = w_top * $urandom_range(5, 80) / 100;
    w_hi = w_top * 83 / 100;
    for (i = 1; i <= n; i++) begin
      now_us += $urandom_range(100000, 1500000);
      if ($urandom_range(0, 5) == 0) send_event(OP_TICK, '0, 48'(now_us));
      send_event(OP_PULSE, VEL_W'(w_hi - (w_hi - w_end) * i / n), 48'(now_us));
    end
    twist = $urandom_range(0, 11);
    case (twist)
      0: begin
        now_us += $urandom_range(0, 500000);
        send_event(OP_PULSE, '0, 48'(now_us));
      end
      1: begin
        w = w_top - $urandom_range(0, 30000);
        now_us += $urandom_range(0, 500000);
        send_event(OP_PULSE, VEL_W'(w < 0 ? 0 : w), 48'(now_us));
      end
      2: begin
        // timestamp runs backwards
        t_back = now_us - $urandom_range(0, 20000000);
        send_event(OP_PULSE, VEL_W'(w_end), 48'(t_back < 0 ? 0 : t_back));
      end
      3: begin
        now_us += $urandom_range(0, 500000);
        send_event(OP_PULSE, VEL_W'($urandom_range(w_top, 24'hFFFFFF)), 48'(now_us));
      end
      4: send_event(OP_CANCEL, '0, 48'(now_us));
      default: ;
    endcase
    dstop = (stop_reg > 10000000) ? 10000000 : stop_reg;
    if ($urandom_range(0, 9) == 0) send_event(OP_TICK, '0, 48'(now_us + dstop - 1));
    now_us += dstop + $urandom_range(0, 300000);
    send_event(OP_TICK, '0, 48'(now_us));
    if ($urandom_range(0, 3) == 0)
      send_event(op_t'($urandom_range(0, 3)), VEL_W'($urandom), 48'(now_us + 1000));
  endtask

  task automatic test_random(int count);
    int goal;
    goal = words_sent + count;
    while (words_sent < goal) begin
      if ($urandom_range(0, 9) == 0)
        send_event(op_t'($urandom_range(0, 3)), VEL_W'($urandom),
                   ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom}) : 48'(now_us));
      else
        spin_session();
    end
  endtask

  // output held off while the sender keeps offering words
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req++;
    @(posedge clk);
    spin_session();
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_addr = CFG_DRAG; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_PULSE;
    drag_reg = RST_DRAG; overall_reg = RST_OVERALL; stop_reg = RST_STOP;
    ph = PH_IDLE; t_start = '0; t_lastp = '0; t_peak = '0; t_final = '0;
    k_run = '0; w_peak = '0; w_final = '0; n_up = '0; n_down = '0;
    iner_val = '0; fcode = FC_NONE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    for (int p = 0; p < 9; p++) begin
      drain();
      case (p)
        0: write_config(RST_DRAG, RST_OVERALL, RST_STOP);
        1: write_config(26'd42949673, 48'hFFFF_FFFF_FFFF, 48'd2000000);
        2: write_config('0, 48'd60000000, 48'd1000000);
        3: write_config(26'd1288491, 48'd30000000, 48'd500000);
        4: write_config(26'd1, 48'd1, 48'd1);
        5: write_config(26'd4294967, 48'd120000000, 48'd3000000);
        6: write_config(DRAG_W'($urandom_range(1, 42949673)),
                        48'($urandom_range(10000000, 200000000)),
                        48'($urandom_range(300000, 3000000)));
        7: write_config(26'd429497, 48'd90000000, 48'hFFFF_FFFF_FFFF);
        default: write_config(26'd858994, 48'd60000000, 48'd2000000);
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      test_random(ITEMS_PER_PHASE);
    end
    drain();
    test_backpressure();
    drain();
    repeat (150) @(posedge clk);

    $display("Sent %0d event words, checked %0d result words", words_sent, words_checked);
    $display("Runs completed: %0d, runs failed: %0d, over 9 register settings",
             n_complete, n_failed);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
